[rtl/core/epoch_seconds_to_calendar_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seconds-to-calendar converter
// Wraps the clocked implication forms that the converter's checks use.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while reset is low.
`define ESC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("converter check failed");

// Next-cycle implication, sampled on clk and disabled while reset is low.
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

[rtl/core/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Widths, calendar constants and constant-divisor helpers for the converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned YEAR_W   = 7;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned YQ_W     = 8;

  // Reciprocals, each rounded up; all exact over the operand ranges used.
  localparam logic [30:0] RECIP_15   = 31'd1145324613;  // 2^34 / 15
  localparam logic [18:0] RECIP_3    = 19'd349526;      // 2^20 / 3
  localparam logic [17:0] RECIP_1461 = 18'd183735;      // 2^28 / 1461
  localparam logic [15:0] RECIP_366  = 16'd45840;       // 2^24 / 366
  localparam logic [15:0] RECIP_365  = 16'd45965;       // 2^24 / 365

  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR   = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_PER_CYCLE  = 16'd1461;
  localparam logic [DAYS_W-1:0] CYCLE_LAST_REM  = 16'd1460;
  localparam logic [8:0]        BASE_YEAR_LOW   = 9'd70;
  localparam logic [DOY_W-1:0]  LEAP_DAY_DOY    = 9'd60;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [DAY_W-1:0]  LEAP_DAY_DOM    = 5'd29;
  localparam logic [DAY_W-1:0]  LAST_DAY_DOM    = 5'd31;

  // Day of year on which the month before each one ends (non-leap year).
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // x / 60 for any 32-bit x, as (x >> 2) / 15.
  function automatic logic [26:0] div60(input logic [31:0] x);
    logic [60:0] p;
    p = 61'(x[31:2]) * 61'(RECIP_15);
    return p[60:34];
  endfunction

  // x / 24 for x below 1572864, as (x >> 3) / 3; the quotient is 16 bits wide.
  function automatic logic [DAYS_W-1:0] div24(input logic [20:0] x);
    logic [36:0] p;
    p = 37'(x[20:3]) * 37'(RECIP_3);
    return p[35:20];
  endfunction

  function automatic logic [5:0] div1461(input logic [DAYS_W-1:0] x);
    logic [33:0] p;
    p = 34'(x) * 34'(RECIP_1461);
    return p[33:28];
  endfunction

  function automatic logic [YQ_W-1:0] div366(input logic [DAYS_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP_366);
    return p[31:24];
  endfunction

  function automatic logic [YQ_W-1:0] div365(input logic [DAYS_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP_365);
    return p[31:24];
  endfunction

  // (70 + q) mod 100 for q up to 255; the sum stays below 400.
  function automatic logic [YEAR_W-1:0] year_low(input logic [YQ_W-1:0] q);
    logic [8:0] s;
    s = BASE_YEAR_LOW + 9'(q);
    if (s >= 9'd300) begin
      s = s - 9'd300;
    end else if (s >= 9'd200) begin
      s = s - 9'd200;
    end else if (s >= 9'd100) begin
      s = s - 9'd100;
    end
    return s[YEAR_W-1:0];
  endfunction

endpackage

[rtl/core/esc_if.sv]
// ----------------------------------------------------------------------------
// esc_if
// Valid/ready channels carrying timestamps in and calendar fields out.
// ----------------------------------------------------------------------------
interface esc_in_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface esc_out_if;
  import esc_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year_two_digit;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  modport source (output valid, output year_two_digit, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year_two_digit, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

[rtl/core/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970 into two-digit year, month, day and time of day.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                  Handshake
//   in_chan  sink       seconds_since_epoch (32 b)               valid/ready
//   out_chan source     year_two_digit, month, day, hour,        valid/ready
//                       minute, second
//
// One item enters per clock cycle while out_chan is not stalled. Each item
// passes through a chain of seven register stages before its result is
// offered on out_chan: five carry the constant-reciprocal divisions, the
// sixth forms the two-digit year and day of year, and the seventh does the
// month search.
// Reset (synchronous, active low) clears only the stage valid bits.
// A stalled result freezes every stage together, so in_chan.ready follows
// out_chan.ready whenever the last stage holds an item.
//
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_chan,
  esc_out_if.source out_chan
);
  import esc_pkg::*;

  // Pipeline advance: every stage moves when the output is empty or taken.
  logic advance;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // Stage 1: total minutes and the low bits of the raw seconds.
  logic [26:0]          q1_r;
  logic [5:0]           tlo1_r;

  // Stage 2: total hours, second of minute, low bits of total minutes.
  logic [20:0]          q2_r;
  logic [5:0]           qlo2_r;
  logic [SECOND_W-1:0]  sec2_r;
  logic [SECOND_W-1:0]  sec2_nxt;

  // Stage 3: whole days since 1970, minute of hour.
  logic [DAYS_W-1:0]    days3_r;
  logic [4:0]           hlo3_r;
  logic [MINUTE_W-1:0]  min3_r;
  logic [MINUTE_W-1:0]  min3_nxt;
  logic [SECOND_W-1:0]  sec3_r;

  // Stage 4: leap days so far, year count for the leap-year last day, hour.
  logic [DAYS_W-1:0]    days4_r;
  logic [5:0]           leaps4_r;
  logic [YQ_W-1:0]      q366_4_r;
  logic [HOUR_W-1:0]    hr4_r;
  logic [HOUR_W-1:0]    hr4_nxt;
  logic [MINUTE_W-1:0]  min4_r;
  logic [SECOND_W-1:0]  sec4_r;

  // Stage 5: last-day flag, leap-free day count and its year count.
  logic                 last5_r;
  logic [DAYS_W-1:0]    dd5_r;
  logic [YQ_W-1:0]      q365_5_r;
  logic [YQ_W-1:0]      q366_5_r;
  logic [HOUR_W-1:0]    hr5_r;
  logic [MINUTE_W-1:0]  min5_r;
  logic [SECOND_W-1:0]  sec5_r;
  logic [DAYS_W-1:0]    cyc_rem;
  logic [DAYS_W-1:0]    dd5_nxt;

  // Stage 6: two-digit year and day of year.
  logic                 last6_r;
  logic [YEAR_W-1:0]    yr6_r;
  logic [DOY_W-1:0]     doy6_r;
  logic [HOUR_W-1:0]    hr6_r;
  logic [MINUTE_W-1:0]  min6_r;
  logic [SECOND_W-1:0]  sec6_r;
  logic [YQ_W-1:0]      yq6_nxt;
  logic [DAYS_W-1:0]    doy6_full;

  // Stage 7: output register.
  logic [YEAR_W-1:0]    yr7_r;
  logic [MONTH_W-1:0]   mon7_r;
  logic [MONTH_W-1:0]   mon7_nxt;
  logic [DAY_W-1:0]     dom7_r;
  logic [DAY_W-1:0]     dom7_nxt;
  logic [HOUR_W-1:0]    hr7_r;
  logic [MINUTE_W-1:0]  min7_r;
  logic [SECOND_W-1:0]  sec7_r;

  // Month search.
  logic                 leap_yr;
  logic [DOY_W-1:0]     doy_adj;
  logic [MONTH_W-1:0]   mon_idx;
  logic [DOY_W-1:0]     dom_full;

  assign advance       = !v7_r || out_chan.ready;
  assign in_chan.ready = advance;

  // The valid bits are the only state that reset has to clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Remainders are formed modulo a power of two just above the divisor, since
  // the true remainder always fits in that many bits.
  always_comb begin
    sec2_nxt = tlo1_r - 6'(12'(q1_r[5:0]) * 12'd60);
    min3_nxt = qlo2_r - 6'(12'(q2_r[5:0]) * 12'd60);
    hr4_nxt  = hlo3_r - 5'(10'(days3_r[4:0]) * 10'd24);
  end

  // The last day of a leap year is where (days + 366) is a whole number of
  // four-year cycles, i.e. where (days + 365) leaves a remainder of 1460.
  always_comb begin
    cyc_rem = (days4_r + DAYS_PER_YEAR) - 16'(22'(leaps4_r) * 22'(DAYS_PER_CYCLE));
    dd5_nxt = days4_r - 16'(leaps4_r);
  end

  always_comb begin
    yq6_nxt   = last5_r ? q366_5_r : q365_5_r;
    doy6_full = dd5_r - 16'(24'(q365_5_r) * 24'(DAYS_PER_YEAR)) + 16'd1;
  end

  // In a two-digit year divisible by four, days after the leap day move back
  // by one, after which the ordinary month table applies.
  always_comb begin
    leap_yr = (yr6_r[1:0] == 2'd0);
    doy_adj = (leap_yr && (doy6_r > LEAP_DAY_DOY)) ? doy6_r - 9'd1 : doy6_r;
    mon_idx = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy_adj > MONTH_START[i]) begin
        mon_idx = MONTH_W'(i);
      end
    end
    dom_full = doy_adj - MONTH_START[mon_idx];
    if (last6_r) begin
      mon7_nxt = MONTH_DEC;
      dom7_nxt = LAST_DAY_DOM;
    end else if (leap_yr && (doy6_r == LEAP_DAY_DOY)) begin
      mon7_nxt = MONTH_FEB;
      dom7_nxt = LEAP_DAY_DOM;
    end else begin
      mon7_nxt = mon_idx + 4'd1;
      dom7_nxt = dom_full[DAY_W-1:0];
    end
  end

  // Payload stages follow the valid bits without a reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      q1_r     <= div60(in_chan.seconds_since_epoch);
      tlo1_r   <= in_chan.seconds_since_epoch[5:0];

      q2_r     <= 21'(div60(32'(q1_r)));
      qlo2_r   <= q1_r[5:0];
      sec2_r   <= sec2_nxt;

      days3_r  <= div24(q2_r);
      hlo3_r   <= q2_r[4:0];
      min3_r   <= min3_nxt;
      sec3_r   <= sec2_r;

      days4_r  <= days3_r;
      leaps4_r <= div1461(days3_r + DAYS_PER_YEAR);
      q366_4_r <= div366(days3_r);
      hr4_r    <= hr4_nxt;
      min4_r   <= min3_r;
      sec4_r   <= sec3_r;

      last5_r  <= (cyc_rem == CYCLE_LAST_REM);
      dd5_r    <= dd5_nxt;
      q365_5_r <= div365(dd5_nxt);
      q366_5_r <= q366_4_r;
      hr5_r    <= hr4_r;
      min5_r   <= min4_r;
      sec5_r   <= sec4_r;

      last6_r  <= last5_r;
      yr6_r    <= year_low(yq6_nxt);
      doy6_r   <= doy6_full[DOY_W-1:0];
      hr6_r    <= hr5_r;
      min6_r   <= min5_r;
      sec6_r   <= sec5_r;

      yr7_r    <= yr6_r;
      mon7_r   <= mon7_nxt;
      dom7_r   <= dom7_nxt;
      hr7_r    <= hr6_r;
      min7_r   <= min6_r;
      sec7_r   <= sec6_r;
    end
  end

  assign out_chan.valid          = v7_r;
  assign out_chan.year_two_digit = yr7_r;
  assign out_chan.month          = mon7_r;
  assign out_chan.day            = dom7_r;
  assign out_chan.hour           = hr7_r;
  assign out_chan.minute         = min7_r;
  assign out_chan.second         = sec7_r;

  // A delivered result always carries a real date and time of day.
  `ESC_ASSERT_IMPLIES(a_month_range, v7_r, (mon7_r >= 4'd1) && (mon7_r <= MONTH_DEC))
  `ESC_ASSERT_IMPLIES(a_day_year_range, v7_r, (dom7_r != 5'd0) && (yr7_r < 7'd100))
  `ESC_ASSERT_IMPLIES(a_time_range, v7_r, (hr7_r < 5'd24) && (min7_r < 6'd60) && (sec7_r < 6'd60))
  // February never runs past the leap day.
  `ESC_ASSERT_IMPLIES(a_feb_len, v7_r && (mon7_r == MONTH_FEB), dom7_r <= LEAP_DAY_DOM)
  // A stalled output freezes the stage feeding it.
  `ESC_ASSERT_NEXT(a_stall_hold, !advance, $stable(yr6_r) && $stable(doy6_r) && $stable(v6_r))

endmodule

[bench/calendar_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar result checker
// Watches both channels of the converter, keeps the dates due for every
// accepted timestamp in order and compares each returned item field by field.
// ----------------------------------------------------------------------------
module calendar_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  esc_in_if           stamp_bus,
  esc_out_if          date_bus,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);
  import esc_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]   year_two_digit;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } calendar_t;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned LEAP_CYCLE    = 1461;
  localparam int unsigned PLAIN_YEAR    = 365;
  localparam int unsigned LEAP_YEAR     = 366;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned FEB_29_DOY    = 60;

  localparam int unsigned DAYS_IN_MONTH [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  calendar_t   expected_dates [$];
  int unsigned fail_tally = 0;

  assign mismatch_count = fail_tally;

  // Date and time of day that a count of seconds since 1970 stands for.
  function automatic calendar_t calendar_of(input logic [EPOCH_W-1:0] stamp);
    int unsigned t, days, yr, doy, m;
    calendar_t   c;
    t        = stamp;
    c.second = SECOND_W'(t % SECS_PER_MIN);
    t        = t / SECS_PER_MIN;
    c.minute = MINUTE_W'(t % MINS_PER_HOUR);
    t        = t / MINS_PER_HOUR;
    c.hour   = HOUR_W'(t % HOURS_PER_DAY);
    days     = t / HOURS_PER_DAY;
    if ((days + LEAP_YEAR) % LEAP_CYCLE == 0) begin
      // Final day of a leap year lands exactly on the cycle boundary.
      yr      = (EPOCH_YEAR + days / LEAP_YEAR) % CENTURY;
      c.month = MONTH_DEC;
      c.day   = LAST_DAY_DOM;
    end else begin
      days = days - (days + PLAIN_YEAR) / LEAP_CYCLE;
      yr   = (EPOCH_YEAR + days / PLAIN_YEAR) % CENTURY;
      doy  = days % PLAIN_YEAR + 1;
      if (yr % 4 == 0 && doy == FEB_29_DOY) begin
        c.month = MONTH_FEB;
        c.day   = LEAP_DAY_DOM;
      end else begin
        if (yr % 4 == 0 && doy > FEB_29_DOY) begin
          doy = doy - 1;
        end
        m = 0;
        while (m < 11 && DAYS_IN_MONTH[m] < doy) begin
          doy = doy - DAYS_IN_MONTH[m];
          m   = m + 1;
        end
        c.month = MONTH_W'(m + 1);
        c.day   = DAY_W'(doy);
      end
    end
    c.year_two_digit = YEAR_W'(yr);
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst_n) begin
      outstanding <= 0;
    end else begin
      if (stamp_bus.valid && stamp_bus.ready) begin
        expected_dates.push_back(calendar_of(stamp_bus.seconds_since_epoch));
      end
      if (date_bus.valid && date_bus.ready) begin
        if (expected_dates.size() == 0) begin
          $error("date item returned with no timestamp outstanding");
          fail_tally++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year_two_digit", 32'(want.year_two_digit),
                      32'(date_bus.year_two_digit));
          check_field("month", 32'(want.month), 32'(date_bus.month));
          check_field("day", 32'(want.day), 32'(date_bus.day));
          check_field("hour", 32'(want.hour), 32'(date_bus.hour));
          check_field("minute", 32'(want.minute), 32'(date_bus.minute));
          check_field("second", 32'(want.second), 32'(date_bus.second));
        end
      end
      outstanding <= expected_dates.size();
    end
  end

endmodule

[bench/tb_epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds-to-calendar converter testbench
// Feeds directed and random timestamps through the converter with random
// stalls on both channels; a checker beside the block predicts every date.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned LEAP_CYCLE     = 1461;
  localparam int unsigned RANDOM_ITEMS   = 480;
  // The final stretch runs at full rate on both sides.
  localparam int unsigned QUIET_ITEMS    = 80;
  localparam int unsigned PHASE_ITEMS    = 60;
  // The pipeline is seven stages deep; allow a little over that at the end.
  localparam int unsigned TAIL_CYCLES    = 12;
  // Stall bursts can follow one another, but a correct run keeps moving
  // items, so this limit leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Day numbers (counted from 1970-01-01) of interesting calendar points.
  localparam int unsigned DAY_1970_DEC_31 = 364;
  localparam int unsigned DAY_1972_FEB_29 = 789;
  localparam int unsigned DAY_1972_DEC_31 = 1095;
  localparam int unsigned DAY_2000_FEB_29 = 11016;
  localparam int unsigned DAY_2000_DEC_31 = 11322;
  localparam int unsigned DAY_2100_FEB_29 = 47541;
  localparam int unsigned DAY_2100_DEC_31 = 47847;
  localparam int unsigned LAST_WHOLE_DAY  = 49709;

  logic clk;
  logic rst_n;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;

  // Percent chances of a gap after an accepted item and of a stall burst at an
  // edge; both change per phase so some stretches run with no idling at all.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          quiet     = 1'b0;

  int unsigned idle_cycles = 0;

  epoch_seconds_to_calendar dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  calendar_result_checker date_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .stamp_bus      (in_ch),
    .date_bus       (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Builds a timestamp from a day number and a time of day.
  function automatic logic [EPOCH_W-1:0] stamp_at(input int unsigned days,
                                                  input int unsigned sec_of_day);
    return EPOCH_W'(days * SECS_PER_DAY + sec_of_day);
  endfunction

  // Offers one timestamp and holds it until the converter takes it. Called
  // and left on a rising edge; the item is accepted at the edge it returns on.
  task automatic offer_stamp(input logic [EPOCH_W-1:0] stamp);
    in_ch.valid               <= 1'b1;
    in_ch.seconds_since_epoch <= stamp;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Possibly drops valid for a burst of idle cycles after an accepted item.
  task automatic maybe_pause_sender;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid               <= 1'b0;
      in_ch.seconds_since_epoch <= $urandom;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Holds the sender back until every outstanding date has come out. The
  // first edge lets the count catch up with the item just accepted.
  task automatic drain_dates;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // Random timestamp, weighted towards the edges of years and leap days
  // where the calendar arithmetic is most likely to go wrong.
  function automatic logic [EPOCH_W-1:0] random_stamp;
    int unsigned pick, cycle, days;
    pick  = $urandom_range(0, 99);
    cycle = $urandom_range(1, 34);
    if (pick < 30) begin
      return $urandom;
    end else if (pick < 50) begin
      // Around the final day of a leap year.
      days = cycle * LEAP_CYCLE - 366 + $urandom_range(0, 6) - 3;
    end else if (pick < 70) begin
      // Around 29 February of a leap year.
      days = cycle * LEAP_CYCLE - 731 + 59 + $urandom_range(0, 4) - 2;
    end else begin
      days = $urandom_range(0, LAST_WHOLE_DAY);
    end
    return stamp_at(days, $urandom_range(0, SECS_PER_DAY - 1));
  endfunction

  // Result side: ready is high except during random stall bursts while a
  // stalling phase is in force.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: reset, a directed set, then the random stream in phases.
  initial begin
    logic [EPOCH_W-1:0] directed [$];
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.seconds_since_epoch = '0;

    // Field extremes, the edges of the time of day, the first and last
    // timestamps, the 2038 sign boundary and alternating bit patterns.
    directed = {
      32'h0000_0000, 32'hFFFF_FFFF, 32'd59, 32'd3599, 32'd86399, 32'd86400,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };
    // End of an ordinary year and the start of the next.
    directed.push_back(stamp_at(DAY_1970_DEC_31, SECS_PER_DAY - 1));
    directed.push_back(stamp_at(DAY_1970_DEC_31 + 1, 0));
    // Leap day and its neighbours in 1972, and the leap day of 2000.
    directed.push_back(stamp_at(DAY_1972_FEB_29 - 1, 43200));
    directed.push_back(stamp_at(DAY_1972_FEB_29, 0));
    directed.push_back(stamp_at(DAY_1972_FEB_29 + 1, 0));
    directed.push_back(stamp_at(DAY_2000_FEB_29, 3723));
    // Final day of a leap year, which takes the special path, and either side.
    directed.push_back(stamp_at(DAY_1972_DEC_31 - 1, SECS_PER_DAY - 1));
    directed.push_back(stamp_at(DAY_1972_DEC_31, 0));
    directed.push_back(stamp_at(DAY_1972_DEC_31 + 1, 0));
    directed.push_back(stamp_at(DAY_2000_DEC_31, SECS_PER_DAY - 1));
    // The century year 2100 is treated as a leap year.
    directed.push_back(stamp_at(DAY_2100_FEB_29, 1));
    directed.push_back(stamp_at(DAY_2100_DEC_31, 7));
    directed.push_back(stamp_at(DAY_2100_DEC_31 + 1, 0));
    directed.push_back(stamp_at(LAST_WHOLE_DAY, SECS_PER_DAY - 1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 10;
    stall_pct = 10;
    foreach (directed[i]) begin
      offer_stamp(directed[i]);
      maybe_pause_sender();
    end

    // Let the directed set drain completely before the random stream.
    drain_dates();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            gap_pct   = 0;
            stall_pct = 0;
          end
          1: begin
            gap_pct   = 20;
            stall_pct = 5;
          end
          2: begin
            gap_pct   = 5;
            stall_pct = 25;
          end
          default: begin
            gap_pct   = 30;
            stall_pct = 30;
          end
        endcase
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_dates();
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      offer_stamp(random_stamp());
      maybe_pause_sender();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/epoch_seconds_to_calendar.sv
bench/calendar_result_checker.sv
bench/tb_epoch_seconds_to_calendar.sv
